/* sv/sdf_pkg.sv */
// Shared constants, result codes and controller/datapath types for the duplicate filter table.
`default_nettype none

package sdf_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int KEY_BITS_DEF    = 48;
	localparam int TIME_W          = 16;
	localparam int CNT_OUT_W       = 7;

	localparam logic [TIME_W-1:0] DUP_WINDOW_RST = 16'd20;

	localparam logic [1:0] OC_INSERTED   = 2'd0;
	localparam logic [1:0] OC_FULL       = 2'd1;
	localparam logic [1:0] OC_REFRESHED  = 2'd2;
	localparam logic [1:0] OC_SUPPRESSED = 2'd3;

	typedef struct packed {
		logic       load_item;
		logic       rd_mid;
		logic       step_search;
		logic       rd_pos;
		logic       init_shift;
		logic       rd_shift;
		logic       wr_shift;
		logic       wr_entry;
		logic       inc_count;
		logic       load_out;
		logic [1:0] outcome;
	} cmd_t;

	typedef struct packed {
		logic search_done;
		logic pos_in_table;
		logic found;
		logic dup;
		logic full;
		logic shift_done;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

/* sv/sdf_if.sv */
// Channel interfaces: report items in, filter results out, window register writes.
`default_nettype none

interface sdf_item_if #(
	parameter int KEY_BITS = sdf_pkg::KEY_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [KEY_BITS-1:0]         node_key;
	logic [sdf_pkg::TIME_W-1:0]  arrival_time;

	modport source (output valid, output node_key, output arrival_time, input ready);
	modport sink (input valid, input node_key, input arrival_time, output ready);
endinterface

interface sdf_result_if;
	logic                          valid;
	logic                          ready;
	logic                          is_duplicate;
	logic [1:0]                    outcome;
	logic [sdf_pkg::CNT_OUT_W-1:0] entries_used;

	modport source (output valid, output is_duplicate, output outcome, output entries_used,
		input ready);
	modport sink (input valid, input is_duplicate, input outcome, input entries_used,
		output ready);
endinterface

interface sdf_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sdf_pkg::TIME_W-1:0] dup_window;

	modport source (output valid, output dup_window, input ready);
	modport sink (input valid, input dup_window, output ready);
endinterface

`default_nettype wire

/* sv/sorted_duplicate_filter_table.sv */
// Top level of the sorted duplicate filter table: controller plus datapath.
//
// Reports enter on the item channel (node_key, arrival_time) and each gives exactly
// one beat on the result channel (is_duplicate, outcome, entries_used). The window
// register is written through the cfg channel, which is always ready; write it only
// while no report is in flight.
// One report is handled at a time. A binary search over the table memory halves the
// range with a registered read and then a compare, for at most ceil(log2(entries+1))
// halvings; then the search is closed, and the hit slot is read and checked when the
// key may already be stored. A new key is first checked for room; each larger entry
// is then moved up by a registered read and a write, the end of the shift is seen and
// the key is written. The result register is then loaded, and the controller goes
// back to idle before it takes the next report.
// The result register parts the two sides: the next report is taken while a result
// waits, and the block only holds in its last step if a second result is due while
// the receiver still stalls the first.
// Reset clears the entry count, restores the window to 20 and empties the result
// register; table contents are not cleared, as only counted entries are ever read.
`default_nettype none

module sorted_duplicate_filter_table #(
	parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = sdf_pkg::KEY_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	sdf_item_if.sink     item,
	sdf_result_if.source result,
	sdf_cfg_if.sink      cfg
);

	sdf_pkg::cmd_t    cmd;
	sdf_pkg::status_t status;
	logic             ready;

	assign item.ready = ready;

	sdf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (ready),
		.status     (status),
		.cmd        (cmd)
	);

	sdf_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.node_key     (item.node_key),
		.arrival_time (item.arrival_time),
		.cmd          (cmd),
		.status       (status),
		.result       (result),
		.cfg          (cfg)
	);

endmodule

`default_nettype wire

/* sv/sdf_datapath.sv */
// Datapath: sorted table memory, search bounds, shift pointer, entry count and result register.
`default_nettype none

module sdf_datapath #(
	parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = sdf_pkg::KEY_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [KEY_BITS-1:0]        node_key,
	input  wire logic [sdf_pkg::TIME_W-1:0] arrival_time,
	input  wire sdf_pkg::cmd_t              cmd,
	output sdf_pkg::status_t                status,
	sdf_result_if.source                    result,
	sdf_cfg_if.sink                         cfg
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TW = sdf_pkg::TIME_W;
	localparam int EW = KEY_BITS + TW;
	localparam int OW = sdf_pkg::CNT_OUT_W;

	logic [EW-1:0]       mem [TABLE_DEPTH];
	logic [EW-1:0]       rdata_q;
	logic [KEY_BITS-1:0] key_q;
	logic [TW-1:0]       time_q;
	logic [CW-1:0]       lo_q;
	logic [CW-1:0]       hi_q;
	logic [CW-1:0]       shift_q;
	logic [CW-1:0]       count_q;
	logic [TW-1:0]       window_q;
	logic                out_valid_q;
	logic                is_dup_q;
	logic [1:0]          outcome_q;
	logic [OW-1:0]       used_q;

	logic [CW:0]         mid_sum;
	logic [CW-1:0]       mid;
	logic [CW-1:0]       shift_prev;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [EW-1:0]       wr_data;
	logic [KEY_BITS-1:0] rd_key;
	logic [TW-1:0]       rd_time;
	logic [TW-1:0]       diff;

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CW:1];
	assign shift_prev = shift_q - CW'(1);
	assign rd_key     = rdata_q[EW-1:TW];
	assign rd_time    = rdata_q[TW-1:0];
	assign diff       = (rd_time >= time_q) ? (rd_time - time_q) : (time_q - rd_time);

	always_comb begin
		rd_en   = cmd.rd_mid | cmd.rd_pos | cmd.rd_shift;
		rd_addr = lo_q[AW-1:0];
		if (cmd.rd_mid) begin
			rd_addr = mid[AW-1:0];
		end else if (cmd.rd_shift) begin
			rd_addr = shift_prev[AW-1:0];
		end
		wr_en   = cmd.wr_shift | cmd.wr_entry;
		wr_addr = lo_q[AW-1:0];
		wr_data = {key_q, time_q};
		if (cmd.wr_shift) begin
			wr_addr = shift_q[AW-1:0];
			wr_data = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Search bounds and shift pointer; lo_q ends as the first slot not below the key.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			key_q  <= node_key;
			time_q <= arrival_time;
			lo_q   <= '0;
			hi_q   <= count_q;
		end else if (cmd.step_search) begin
			if (rd_key < key_q) begin
				lo_q <= mid + CW'(1);
			end else begin
				hi_q <= mid;
			end
		end
		if (cmd.init_shift) begin
			shift_q <= count_q;
		end else if (cmd.wr_shift) begin
			shift_q <= shift_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			window_q    <= sdf_pkg::DUP_WINDOW_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.inc_count) begin
				count_q <= count_q + CW'(1);
			end
			if (cfg.valid) begin
				window_q <= cfg.dup_window;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			is_dup_q  <= (cmd.outcome == sdf_pkg::OC_SUPPRESSED);
			outcome_q <= cmd.outcome;
			used_q    <= OW'(count_q);
		end
	end

	always_comb begin
		status.search_done  = (lo_q == hi_q);
		status.pos_in_table = (lo_q < count_q);
		status.found        = (rd_key == key_q);
		status.dup          = (diff < window_q);
		status.full         = (count_q == CW'(TABLE_DEPTH));
		status.shift_done   = (shift_q == lo_q);
		status.out_free     = !out_valid_q || result.ready;
	end

	assign cfg.ready           = 1'b1;
	assign result.valid        = out_valid_q;
	assign result.is_duplicate = is_dup_q;
	assign result.outcome      = outcome_q;
	assign result.entries_used = used_q;

endmodule

`default_nettype wire

/* sv/sdf_ctrl.sv */
// Controller: sequences search, hit check, shift-insert and result hand-off for one report.
`default_nettype none

module sdf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire sdf_pkg::status_t status,
	output sdf_pkg::cmd_t         cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_TEST = 4'd1;
	localparam logic [3:0] ST_CMP  = 4'd2;
	localparam logic [3:0] ST_CHK  = 4'd3;
	localparam logic [3:0] ST_NEW  = 4'd4;
	localparam logic [3:0] ST_SHR  = 4'd5;
	localparam logic [3:0] ST_SHW  = 4'd6;
	localparam logic [3:0] ST_INS  = 4'd7;
	localparam logic [3:0] ST_RES  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic [1:0] outcome_q;
	logic [1:0] outcome_d;
	logic       outcome_set;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		outcome_d   = outcome_q;
		outcome_set = 1'b0;
		cmd         = '0;
		cmd.outcome = outcome_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_TEST;
				end
			end
			ST_TEST: begin
				if (!status.search_done) begin
					cmd.rd_mid = 1'b1;
					state_d    = ST_CMP;
				end else if (status.pos_in_table) begin
					cmd.rd_pos = 1'b1;
					state_d    = ST_CHK;
				end else begin
					state_d = ST_NEW;
				end
			end
			ST_CMP: begin
				cmd.step_search = 1'b1;
				state_d         = ST_TEST;
			end
			ST_CHK: begin
				if (status.found) begin
					outcome_set = 1'b1;
					if (status.dup) begin
						outcome_d = sdf_pkg::OC_SUPPRESSED;
					end else begin
						cmd.wr_entry = 1'b1;
						outcome_d    = sdf_pkg::OC_REFRESHED;
					end
					state_d = ST_RES;
				end else begin
					state_d = ST_NEW;
				end
			end
			ST_NEW: begin
				if (status.full) begin
					outcome_set = 1'b1;
					outcome_d   = sdf_pkg::OC_FULL;
					state_d     = ST_RES;
				end else begin
					cmd.init_shift = 1'b1;
					state_d        = ST_SHR;
				end
			end
			ST_SHR: begin
				if (status.shift_done) begin
					state_d = ST_INS;
				end else begin
					cmd.rd_shift = 1'b1;
					state_d      = ST_SHW;
				end
			end
			ST_SHW: begin
				cmd.wr_shift = 1'b1;
				state_d      = ST_SHR;
			end
			ST_INS: begin
				cmd.wr_entry  = 1'b1;
				cmd.inc_count = 1'b1;
				outcome_set   = 1'b1;
				outcome_d     = sdf_pkg::OC_INSERTED;
				state_d       = ST_RES;
			end
			ST_RES: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (outcome_set) begin
			outcome_q <= outcome_d;
		end
	end

endmodule

`default_nettype wire

/* sv/sdf_checker.sv */
// Port-level checker for the duplicate filter table and its bind to the top level.
`default_nettype none

module sdf_checker #(
	parameter int TABLE_DEPTH = sdf_pkg::TABLE_DEPTH_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          item_valid,
	input wire logic                          item_ready,
	input wire logic                          result_valid,
	input wire logic                          result_ready,
	input wire logic                          is_duplicate,
	input wire logic [1:0]                    outcome,
	input wire logic [sdf_pkg::CNT_OUT_W-1:0] entries_used
);

	localparam int OW = sdf_pkg::CNT_OUT_W;
	localparam logic [OW-1:0] USED_FULL = OW'(TABLE_DEPTH);

	// Only one report is in flight: an accepted beat closes the item channel next cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("item accepted while another report is in flight");

	a_dup_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_duplicate == (outcome == sdf_pkg::OC_SUPPRESSED)))
		else $error("is_duplicate disagrees with outcome");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && outcome == sdf_pkg::OC_FULL) |-> (entries_used == USED_FULL))
		else $error("table reported full with a partial entry count");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |=>
			(result_valid && $stable(outcome) && $stable(entries_used)))
		else $error("stalled result beat changed");

endmodule

bind sorted_duplicate_filter_table sdf_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_sdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.is_duplicate (result.is_duplicate),
	.outcome      (result.outcome),
	.entries_used (result.entries_used)
);

`default_nettype wire
